// File: design/h264fu_pkg.sv
// Shared types and constants for the H.264 FU-A packetizer.
package h264fu_pkg;

   localparam int BYTE_W     = 8;
   localparam int ULEN_W     = 16;
   localparam int MAXP_W     = 11;
   localparam int STEP_W     = 12;
   localparam int SC_BYTES   = 4;
   localparam int HDR_POS    = 4;
   localparam int PRE_BYTES  = 5;
   localparam int FRAG_HDR_N = 6;
   localparam int IDX_W      = 3;

   localparam logic [MAXP_W-1:0] MAXP_RESET = 11'd1000;

   localparam logic [BYTE_W-1:0] NRI_MASK  = 8'h60;
   localparam logic [BYTE_W-1:0] FU_A_TYPE = 8'h1C;
   localparam logic [BYTE_W-1:0] TYPE_MASK = 8'h1F;
   localparam logic [BYTE_W-1:0] S_BIT     = 8'h80;
   localparam logic [BYTE_W-1:0] E_BIT     = 8'h40;

   localparam logic [STEP_W-1:0] STEP_SINGLE = 12'd3600;
   localparam logic [STEP_W-1:0] STEP_FRAG   = 12'd1800;

   typedef struct packed {
      logic [SC_BYTES-1:0][BYTE_W-1:0] start_code;
      logic [BYTE_W-1:0]               fu_ind;
      logic [BYTE_W-1:0]               fu_hdr;
      logic [BYTE_W-1:0]               data;
      logic                            with_hdr;
      logic                            eop;
      logic                            marker;
   } run_type;

endpackage

// File: design/h264fu_if.sv
// Valid/ready channel interfaces for input bytes, output bytes and configuration.
interface h264fu_req_if;
   import h264fu_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic [ULEN_W-1:0] unit_length;
   modport source (output valid, output data_byte, output unit_length, input ready);
   modport sink   (input valid, input data_byte, input unit_length, output ready);
endinterface

interface h264fu_rsp_if;
   import h264fu_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              end_of_packet;
   logic              last_of_run;
   logic              marker;
   logic [STEP_W-1:0] timestamp_step;
   modport source (output valid, output out_byte, output end_of_packet,
                   output last_of_run, output marker, output timestamp_step,
                   input ready);
   modport sink   (input valid, input out_byte, input end_of_packet,
                   input last_of_run, input marker, input timestamp_step,
                   output ready);
endinterface

interface h264fu_csr_if;
   import h264fu_pkg::*;
   logic              valid;
   logic              ready;
   logic [MAXP_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: design/h264fu_ctl.sv
// Unit tracking state, max_payload register and per-byte run builder.
module h264fu_ctl #(
   parameter int MAX_UNIT_BYTES = 65535
) (
   input  logic                  clock,
   input  logic                  reset,
   h264fu_req_if.sink            req,
   h264fu_csr_if.sink            csr,
   input  logic                  take_ok,
   output logic                  load,
   output h264fu_pkg::run_type   run
);
   import h264fu_pkg::*;

   localparam int LenRaw = $clog2(MAX_UNIT_BYTES + 1);
   localparam int LenW   = (LenRaw < ULEN_W) ? LenRaw : ULEN_W;

   logic [MAXP_W-1:0]               max_payload_ff;
   logic [LenW-1:0]                 unit_len_ff, unit_len_in;
   logic [LenW-1:0]                 byte_pos_ff, byte_pos_in;
   logic [LenW-1:0]                 payload_left_ff, payload_left_in;
   logic [MAXP_W-1:0]               frag_fill_ff, frag_fill_in;
   logic                            first_frag_ff, first_frag_in;
   logic [SC_BYTES-1:0][BYTE_W-1:0] start_code_ff, start_code_in;
   logic [BYTE_W-1:0]               nal_header_ff, nal_header_in;

   logic              accept;
   logic              first;
   logic [LenW-1:0]   len_sat;
   logic [LenW-1:0]   len_eff;
   logic [LenW-1:0]   pl_cur;
   logic [LenW:0]     pos_inc;
   logic [MAXP_W-1:0] maxp;
   logic [MAXP_W-1:0] ff_cur;
   logic [MAXP_W-1:0] ff_next;
   logic              ffirst_cur;
   logic              single;
   logic              last_frag;
   logic              frag_eop;
   logic [BYTE_W-1:0] hdr_flags;

   assign accept    = req.valid && req.ready;
   assign req.ready = take_ok;
   assign csr.ready = 1'b1;

   always_comb begin
      first = (byte_pos_ff == '0);
      maxp  = (max_payload_ff == '0) ? MAXP_W'(1) : max_payload_ff;

      if (req.unit_length == '0) begin
         len_sat = LenW'(1);
      end else if (32'(req.unit_length) > 32'(MAX_UNIT_BYTES)) begin
         len_sat = LenW'(MAX_UNIT_BYTES);
      end else begin
         len_sat = LenW'(req.unit_length);
      end

      len_eff    = first ? len_sat : unit_len_ff;
      ff_cur     = first ? '0 : frag_fill_ff;
      ffirst_cur = first ? 1'b1 : first_frag_ff;
      if (first) begin
         pl_cur = (len_sat > LenW'(PRE_BYTES)) ? len_sat - LenW'(PRE_BYTES) : '0;
      end else begin
         pl_cur = payload_left_ff;
      end

      pos_inc   = {1'b0, byte_pos_ff} + (LenW+1)'(1);
      single    = ULEN_W'(len_eff) <= ULEN_W'(maxp);
      last_frag = ULEN_W'(pl_cur) <= ULEN_W'(maxp);
      ff_next   = ff_cur + MAXP_W'(1);
      payload_left_in = (pl_cur != '0) ? pl_cur - LenW'(1) : '0;
      frag_eop  = (ff_next >= maxp) || (payload_left_in == '0);

      if (ffirst_cur) begin
         hdr_flags = S_BIT;
      end else if (last_frag) begin
         hdr_flags = E_BIT;
      end else begin
         hdr_flags = '0;
      end

      unit_len_in   = len_eff;
      byte_pos_in   = (pos_inc >= {1'b0, len_eff}) ? '0 : pos_inc[LenW-1:0];
      frag_fill_in  = ff_cur;
      first_frag_in = ffirst_cur;
      start_code_in = start_code_ff;
      nal_header_in = nal_header_ff;

      run.start_code = start_code_ff;
      run.fu_ind     = (nal_header_ff & NRI_MASK) | FU_A_TYPE;
      run.fu_hdr     = (nal_header_ff & TYPE_MASK) | hdr_flags;
      run.data       = req.data_byte;
      run.with_hdr   = 1'b0;
      run.eop        = 1'b0;
      run.marker     = 1'b0;
      load           = 1'b0;

      if (single) begin
         payload_left_in = pl_cur;
         run.eop         = (pos_inc >= {1'b0, len_eff});
         run.marker      = 1'b1;
         load            = accept;
      end else if (byte_pos_ff < LenW'(HDR_POS)) begin
         payload_left_in = pl_cur;
         start_code_in[byte_pos_ff[1:0]] = req.data_byte;
      end else if (byte_pos_ff == LenW'(HDR_POS)) begin
         payload_left_in = pl_cur;
         nal_header_in   = req.data_byte;
      end else begin
         run.with_hdr = (ff_cur == '0);
         run.eop      = frag_eop;
         frag_fill_in = frag_eop ? '0 : ff_next;
         if (ff_cur == '0) begin
            first_frag_in = 1'b0;
         end
         load = accept;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff  <= MAXP_RESET;
         unit_len_ff     <= '0;
         byte_pos_ff     <= '0;
         payload_left_ff <= '0;
         frag_fill_ff    <= '0;
         first_frag_ff   <= 1'b1;
      end else begin
         if (csr.valid && csr.ready) begin
            max_payload_ff <= csr.data;
         end
         if (accept) begin
            unit_len_ff     <= unit_len_in;
            byte_pos_ff     <= byte_pos_in;
            payload_left_ff <= payload_left_in;
            frag_fill_ff    <= frag_fill_in;
            first_frag_ff   <= first_frag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         start_code_ff <= start_code_in;
         nal_header_ff <= nal_header_in;
      end
   end

endmodule

// File: design/h264fu_emit.sv
// Result register and byte sequencer for one run of output transactions.
module h264fu_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  h264fu_pkg::run_type run,
   output logic                take_ok,
   h264fu_rsp_if.source        rsp
);
   import h264fu_pkg::*;

   run_type          run_ff;
   logic             busy_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             take;
   logic             at_last;
   logic             on_hdr;

   assign take    = rsp.valid && rsp.ready;
   assign at_last = !run_ff.with_hdr || (idx_ff == IDX_W'(FRAG_HDR_N));
   assign take_ok = !busy_ff || (take && at_last);
   assign on_hdr  = run_ff.with_hdr && (idx_ff < IDX_W'(FRAG_HDR_N));

   always_comb begin
      rsp.valid          = busy_ff;
      rsp.out_byte       = run_ff.data;
      rsp.end_of_packet  = run_ff.eop;
      rsp.last_of_run    = 1'b1;
      rsp.marker         = run_ff.marker;
      rsp.timestamp_step = run_ff.marker ? STEP_SINGLE : STEP_FRAG;
      if (on_hdr) begin
         rsp.end_of_packet = 1'b0;
         rsp.last_of_run   = 1'b0;
         case (idx_ff)
            IDX_W'(SC_BYTES):     rsp.out_byte = run_ff.fu_ind;
            IDX_W'(SC_BYTES + 1): rsp.out_byte = run_ff.fu_hdr;
            default:              rsp.out_byte = run_ff.start_code[idx_ff[1:0]];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (take) begin
         if (at_last) begin
            busy_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         run_ff <= run;
      end
   end

endmodule

// File: design/h264_fu_a_packetizer_unit.sv
// Top level of the H.264 FU-A packetizer: byte in, RTP payload bytes out.
//
//   channel  dir  payload                                           transaction
//   req      in   data_byte, unit_length                            one NAL byte
//   rsp      out  out_byte, end_of_packet, last_of_run, marker,     one packet byte
//                 timestamp_step
//   csr      in   data (max_payload)                                register write
//
// A byte that yields one output is taken every cycle while rsp is ready.
// A byte that opens a fragment yields seven outputs and holds req until the last of them is taken.
// Start code and NAL header bytes of a fragmented unit yield none.
// req stays ready while the last output of the current run is being taken.
// reset is synchronous; max_payload returns to 1000 and the unit state clears.
module h264_fu_a_packetizer_unit #(
   parameter int MAX_UNIT_BYTES = 65535
) (
   input  logic          clock,
   input  logic          reset,
   h264fu_req_if.sink    req,
   h264fu_rsp_if.source  rsp,
   h264fu_csr_if.sink    csr
);
   import h264fu_pkg::*;

   logic    take_ok;
   logic    load;
   run_type run;

   h264fu_ctl #(
      .MAX_UNIT_BYTES(MAX_UNIT_BYTES)
   ) u_ctl (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .csr     (csr),
      .take_ok (take_ok),
      .load    (load),
      .run     (run)
   );

   h264fu_emit u_emit (
      .clock   (clock),
      .reset   (reset),
      .load    (load),
      .run     (run),
      .take_ok (take_ok),
      .rsp     (rsp)
   );

endmodule
